### rtl/ssf_pkg.sv
// Shared types, codes and the microcode control store of the state-space filter.
`timescale 1ns / 1ps

package ssf_pkg;

  // Stream payload widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned CFG_W     = 4;

  // Microcode step addresses
  localparam logic [2:0] PC_IDLE   = 3'd0;
  localparam logic [2:0] PC_D      = 3'd1;
  localparam logic [2:0] PC_C      = 3'd2;
  localparam logic [2:0] PC_B      = 3'd3;
  localparam logic [2:0] PC_A      = 3'd4;
  localparam logic [2:0] PC_DRAIN  = 3'd5;
  localparam logic [2:0] PC_COMMIT = 3'd6;

  // Which coefficient block a term reads
  typedef enum logic [1:0] {
    SEL_D = 2'd0,
    SEL_C = 2'd1,
    SEL_B = 2'd2,
    SEL_A = 2'd3
  } coef_sel_e;

  // When an issued term closes its sum
  typedef enum logic [1:0] {
    LAST_NEVER  = 2'd0,
    LAST_N_ZERO = 2'd1,
    LAST_J_LAST = 2'd2
  } last_sel_e;

  // Sequencer conditions, used both for holding a step and for jumping
  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_START  = 3'd2,
    COND_J_MORE    = 3'd3,
    COND_ROW_MORE  = 3'd4,
    COND_N_ZERO    = 3'd5,
    COND_PIPE_BUSY = 3'd6,
    COND_OUT_BUSY  = 3'd7
  } cond_e;

  // One control word of the program
  typedef struct packed {
    logic      accept;
    logic      issue;
    coef_sel_e coef_sel;
    logic      opnd_x;
    logic      first;
    last_sel_e last_sel;
    logic      dest_x;
    logic      j_step;
    logic      i_step;
    logic      clr_ij;
    logic      commit;
    cond_e     hold;
    cond_e     jump;
    logic [2:0] target;
  } ucode_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic      accept;
    logic      issue;
    coef_sel_e coef_sel;
    logic      opnd_x;
    logic      first;
    logic      last;
    logic      dest_x;
    logic      commit;
  } seq_ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic n_zero;
    logic pipe_busy;
    logic out_busy;
  } seq_status_t;

  // Control store: output sum first, then one row of the state update at a time
  function automatic ucode_t ucode_rom(input logic [2:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      PC_IDLE: begin
        w.accept = 1'b1;
        w.clr_ij = 1'b1;
        w.hold   = COND_NO_START;
      end
      PC_D: begin
        w.issue    = 1'b1;
        w.coef_sel = SEL_D;
        w.first    = 1'b1;
        w.last_sel = LAST_N_ZERO;
        w.jump     = COND_N_ZERO;
        w.target   = PC_DRAIN;
      end
      PC_C: begin
        w.issue    = 1'b1;
        w.coef_sel = SEL_C;
        w.opnd_x   = 1'b1;
        w.last_sel = LAST_J_LAST;
        w.j_step   = 1'b1;
        w.hold     = COND_J_MORE;
      end
      PC_B: begin
        w.issue    = 1'b1;
        w.coef_sel = SEL_B;
        w.first    = 1'b1;
        w.dest_x   = 1'b1;
      end
      PC_A: begin
        w.issue    = 1'b1;
        w.coef_sel = SEL_A;
        w.opnd_x   = 1'b1;
        w.last_sel = LAST_J_LAST;
        w.dest_x   = 1'b1;
        w.j_step   = 1'b1;
        w.i_step   = 1'b1;
        w.hold     = COND_J_MORE;
        w.jump     = COND_ROW_MORE;
        w.target   = PC_B;
      end
      PC_DRAIN: begin
        w.hold = COND_PIPE_BUSY;
      end
      PC_COMMIT: begin
        w.commit = 1'b1;
        w.hold   = COND_OUT_BUSY;
        w.jump   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
      default: begin
        w.jump   = COND_ALWAYS;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/ssf_sequencer.sv
// Microcode sequencer: step counter, row and column counters and control decode.
`timescale 1ns / 1ps

module ssf_sequencer #(
  parameter int MAX_ORDER = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(MAX_ORDER+1)-1:0]  n_i,
  input  ssf_pkg::seq_status_t            status_i,
  output ssf_pkg::seq_ctrl_t              ctrl_o,
  output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] i_o,
  output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] j_o
);
  import ssf_pkg::*;

  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic [2:0]    pc_q, pc_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [NW:0]   j_plus1, i_plus1;
  logic          j_last, row_more, held, jumped;
  ucode_t        word;

  // Condition evaluation
  function automatic logic cond_true(input cond_e c, input seq_status_t s,
                                     input logic jl, input logic rm);
    logic r;
    case (c)
      COND_NONE:      r = 1'b0;
      COND_ALWAYS:    r = 1'b1;
      COND_NO_START:  r = !s.start;
      COND_J_MORE:    r = !jl;
      COND_ROW_MORE:  r = rm;
      COND_N_ZERO:    r = s.n_zero;
      COND_PIPE_BUSY: r = s.pipe_busy;
      COND_OUT_BUSY:  r = s.out_busy;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  // Fetch the control word and decide the next step
  assign word     = ucode_rom(pc_q);
  assign j_plus1  = (NW+1)'(j_q) + (NW+1)'(1);
  assign i_plus1  = (NW+1)'(i_q) + (NW+1)'(1);
  assign j_last   = (j_plus1 == (NW+1)'(n_i));
  assign row_more = (i_plus1 != (NW+1)'(n_i));
  assign held     = cond_true(word.hold, status_i, j_last, row_more);
  assign jumped   = cond_true(word.jump, status_i, j_last, row_more);

  always_comb begin
    if (held) begin
      pc_d = pc_q;
    end else if (jumped) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 3'd1;
    end
  end

  // Column and row counters
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (word.clr_ij) begin
      i_d = '0;
      j_d = '0;
    end else begin
      if (word.j_step) begin
        j_d = j_last ? '0 : IW'(j_plus1);
      end
      if (word.i_step && j_last) begin
        i_d = IW'(i_plus1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
      i_q  <= '0;
      j_q  <= '0;
    end else begin
      pc_q <= pc_d;
      i_q  <= i_d;
      j_q  <= j_d;
    end
  end

  // Control out to the datapath
  always_comb begin
    ctrl_o.accept   = word.accept;
    ctrl_o.issue    = word.issue;
    ctrl_o.coef_sel = word.coef_sel;
    ctrl_o.opnd_x   = word.opnd_x;
    ctrl_o.first    = word.first;
    ctrl_o.dest_x   = word.dest_x;
    ctrl_o.commit   = word.commit && !held;
    case (word.last_sel)
      LAST_NEVER:  ctrl_o.last = 1'b0;
      LAST_N_ZERO: ctrl_o.last = status_i.n_zero;
      LAST_J_LAST: ctrl_o.last = j_last;
      default:     ctrl_o.last = 1'b0;
    endcase
  end

  assign i_o = i_q;
  assign j_o = j_q;

endmodule

### rtl/state_space_filter.sv
// Top level of the single-input single-output fixed-point state-space filter.
// A load request writes the coefficient store when accepted. A sample request at order n
// has its result registered at the commit step: one product per cycle, 1 + n products
// for the output and 1 + n per row, then the pipeline drains before the commit.
// One sample is in work at a time, so no sample is taken before the last one commits; the next
// request is taken while a result waits. Reset clears the state, order and output, not the store.
`timescale 1ns / 1ps

module state_space_filter #(
  parameter int MAX_ORDER      = 8,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write: order_in_use
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssf_pkg::CFG_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // coef_index [6:0], coef_value [22:7], sample_in [38:23], zero [39]
  input  logic [ssf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode [0]
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample_out [15:0]
  output logic [ssf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // saturated [0]
  output logic [0:0]                    m_axis_tuser
);
  import ssf_pkg::*;

  localparam int NW         = $clog2(MAX_ORDER + 1);
  localparam int IW         = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int B_BASE     = MAX_ORDER * MAX_ORDER;
  localparam int C_BASE     = B_BASE + MAX_ORDER;
  localparam int D_SLOT     = C_BASE + MAX_ORDER;
  localparam int COEF_DEPTH = D_SLOT + 1;
  localparam int AW         = $clog2(COEF_DEPTH);
  localparam int ACC_W      = 52 + $clog2(MAX_ORDER + 1);

  localparam logic signed [ACC_W-1:0] HALF_X =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_Y =
    {{(ACC_W-1){1'b0}}, 1'b1} << (2*COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] X_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] X_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-15){1'b0}}, {15{1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = {{(ACC_W-15){1'b1}}, {15{1'b0}}};

  // Tag that travels with each product through the pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic dest_x;
    logic scale_u;
  } tag_t;

  // Request fields
  logic [6:0]         in_index;
  logic signed [15:0] in_value, in_sample;
  logic               load_req, start_req;

  // Registers
  logic [CFG_W-1:0]   order_q;
  logic signed [15:0] u_q;
  logic               last_q, sat_q;
  logic signed [31:0] x_q      [MAX_ORDER];
  logic signed [31:0] next_x_q [MAX_ORDER];
  logic [15:0]        coef_mem [COEF_DEPTH];
  logic signed [15:0] coef_rd_q;
  logic signed [31:0] opnd_q;
  logic signed [47:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  tag_t               tag1_q, tag2_q, tag3_q;
  logic [IW-1:0]      row1_q, row2_q, row3_q;
  logic signed [15:0] y_q;
  logic               out_valid_q;
  logic [15:0]        out_data_q;
  logic               out_sat_q;

  // Sequencer interface
  logic [NW-1:0]      n_use;
  seq_status_t        status;
  seq_ctrl_t          ctrl;
  logic [IW-1:0]      seq_i, seq_j;
  logic [AW-1:0]      rd_addr;

  // Datapath combinational values
  logic signed [ACC_W-1:0] term, rnd_x, rnd_y;
  logic signed [31:0]      x_new;
  logic signed [15:0]      y_new;
  logic                    x_clip, y_clip, finish;

  assign in_index  = s_axis_tdata[6:0];
  assign in_value  = s_axis_tdata[22:7];
  assign in_sample = s_axis_tdata[38:23];
  assign load_req  = s_axis_tvalid && s_axis_tready && !s_axis_tuser[0];
  assign start_req = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ctrl.accept;

  // Orders above the built maximum act as the maximum
  assign n_use = (32'(order_q) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_q);

  assign status.start     = start_req;
  assign status.n_zero    = (n_use == '0);
  assign status.pipe_busy = tag1_q.valid || tag2_q.valid || tag3_q.valid;
  assign status.out_busy  = out_valid_q && !m_axis_tready;

  ssf_sequencer #(
    .MAX_ORDER(MAX_ORDER)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_i     (n_use),
    .status_i(status),
    .ctrl_o  (ctrl),
    .i_o     (seq_i),
    .j_o     (seq_j)
  );

  // Coefficient address for the issued term
  always_comb begin
    case (ctrl.coef_sel)
      SEL_D:   rd_addr = AW'(D_SLOT);
      SEL_C:   rd_addr = AW'(C_BASE + int'(seq_j));
      SEL_B:   rd_addr = AW'(B_BASE + int'(seq_i));
      SEL_A:   rd_addr = AW'(int'(seq_i) * MAX_ORDER + int'(seq_j));
      default: rd_addr = AW'(D_SLOT);
    endcase
  end

  // Coefficient store: written by load requests, read by issued terms
  always_ff @(posedge clk_i) begin
    if (load_req && (32'(in_index) < COEF_DEPTH)) begin
      coef_mem[AW'(in_index)] <= in_value;
    end
    coef_rd_q <= $signed(coef_mem[rd_addr]);
  end

  // Operand, product and accumulate stages
  assign term = tag2_q.scale_u ? (ACC_W'(prod_q) <<< COEF_FRAC_BITS) : ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    opnd_q <= ctrl.opnd_x ? x_q[seq_j] : 32'(u_q);
    row1_q <= seq_i;
    prod_q <= 48'(coef_rd_q) * 48'(opnd_q);
    row2_q <= row1_q;
    acc_q  <= tag2_q.first ? term : acc_q + term;
    row3_q <= row2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q.valid   <= ctrl.issue;
      tag1_q.first   <= ctrl.first;
      tag1_q.last    <= ctrl.last;
      tag1_q.dest_x  <= ctrl.dest_x;
      tag1_q.scale_u <= !ctrl.opnd_x;
      tag2_q         <= tag1_q;
      tag3_q         <= tag2_q;
    end
  end

  // Rounding half up and saturation of a finished sum
  assign rnd_x  = (acc_q + HALF_X) >>> COEF_FRAC_BITS;
  assign rnd_y  = (acc_q + HALF_Y) >>> (2*COEF_FRAC_BITS);
  assign finish = tag3_q.valid && tag3_q.last;

  always_comb begin
    x_clip = 1'b1;
    if (rnd_x > X_MAX) begin
      x_new = 32'(X_MAX);
    end else if (rnd_x < X_MIN) begin
      x_new = 32'(X_MIN);
    end else begin
      x_new  = 32'(rnd_x);
      x_clip = 1'b0;
    end
    y_clip = 1'b1;
    if (rnd_y > Y_MAX) begin
      y_new = 16'(Y_MAX);
    end else if (rnd_y < Y_MIN) begin
      y_new = 16'(Y_MIN);
    end else begin
      y_new  = 16'(rnd_y);
      y_clip = 1'b0;
    end
  end

  // Sample context, state vectors and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= '0;
      u_q         <= '0;
      last_q      <= 1'b0;
      sat_q       <= 1'b0;
      y_q         <= '0;
      x_q         <= '{default: '0};
      next_x_q    <= '{default: '0};
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        order_q <= cfg_data_i;
      end
      if (start_req) begin
        u_q      <= in_sample;
        last_q   <= s_axis_tlast;
        sat_q    <= 1'b0;
        next_x_q <= '{default: '0};
      end else if (finish) begin
        if (tag3_q.dest_x) begin
          next_x_q[row3_q] <= x_new;
          sat_q            <= sat_q | x_clip;
        end else begin
          y_q   <= y_new;
          sat_q <= sat_q | y_clip;
        end
      end
      if (ctrl.commit) begin
        if (last_q) begin
          x_q <= '{default: '0};
        end else begin
          x_q <= next_x_q;
        end
        out_valid_q <= 1'b1;
        out_data_q  <= y_q;
        out_sat_q   <= sat_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

endmodule
